// ===== rtl/lnab_pkg.sv =====
package lnab_pkg;

    localparam int NUM_BINS   = 360;
    localparam int BIN_W      = 9;
    localparam int ANGLE_W    = 16;
    localparam int DIST_W     = 16;

    // quotient floor(angle/100) = floor(angle * QUOT_MUL / 2^QUOT_SHIFT), exact for every 16-bit angle
    localparam int QUOT_SHIFT = 23;
    localparam int QUOT_W     = 10;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = ANGLE_W + MUL_W;
    localparam logic [MUL_W-1:0] QUOT_MUL = 17'd83887;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 1'b1;
    localparam logic [DIST_W-1:0] RANGE_MIN_RST = 16'd150;
    localparam logic [DIST_W-1:0] RANGE_MAX_RST = 16'd6000;

    localparam logic [BIN_W-1:0]  LAST_BIN = 9'(NUM_BINS - 1);
    localparam logic [QUOT_W-1:0] BINS_Q   = 10'(NUM_BINS);

    typedef enum logic {
        REQ_POINT = 1'b0,
        REQ_READ  = 1'b1
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic [ANGLE_W-1:0] bearing_cdeg;
        logic [DIST_W-1:0]  dist_mm;
        logic [BIN_W-1:0]   read_bin;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]  out_bin;
        logic [DIST_W-1:0] out_dist_mm;
        logic              out_valid;
    } t_out_item;

    typedef struct packed {
        t_req              kind;
        logic [BIN_W-1:0]  bin;
        logic [DIST_W-1:0] dist_mm;
        logic              bad_bin;
    } t_cmd;

    typedef struct packed {
        logic [DIST_W-1:0] min_mm;
        logic [DIST_W-1:0] max_mm;
    } t_range;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_DATA
    } t_back_state;

endpackage

// ===== rtl/lnab_ram.sv =====
module lnab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 360
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lnab_front.sv =====
module lnab_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  lnab_pkg::t_in_item              i_item,
    input  logic [lnab_pkg::FIFO_CNT_W-1:0] i_fifo_cnt,
    input  logic                            i_clearing,
    output logic                            o_busy,
    output logic                            o_push,
    output lnab_pkg::t_cmd                  o_cmd
);
    import lnab_pkg::*;

    localparam int USED_W = FIFO_CNT_W + 1;

    logic                 w_accept;
    logic                 w_keep;
    logic [USED_W-1:0]    w_used;
    logic [PROD_W-1:0]    w_prod;
    logic [QUOT_W-1:0]    w_q;

    logic                 r_s0_vld;
    t_in_item             r_s0;
    logic                 r_s1_vld;
    t_req                 r_s1_kind;
    logic [QUOT_W-1:0]    r_s1_q;
    logic [DIST_W-1:0]    r_s1_dist;
    logic [BIN_W-1:0]     r_s1_rbin;

    assign w_used = {1'b0, i_fifo_cnt} + USED_W'(r_s0_vld) + USED_W'(r_s1_vld);
    assign o_busy = i_clearing || (w_used >= USED_W'(FIFO_DEPTH));
    assign w_accept = i_start && !o_busy;
    // point with no return leaves the store as it is
    assign w_keep = (i_item.req_type == REQ_READ) || (i_item.dist_mm != '0);

    assign w_prod = PROD_W'(r_s0.bearing_cdeg) * PROD_W'(QUOT_MUL);
    assign w_q    = w_prod[QUOT_SHIFT +: QUOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s0_vld <= w_accept && w_keep;
            r_s1_vld <= r_s0_vld;
        end
        if (w_accept) begin
            r_s0 <= i_item;
        end
        r_s1_kind <= r_s0.req_type;
        r_s1_q    <= w_q;
        r_s1_dist <= r_s0.dist_mm;
        r_s1_rbin <= r_s0.read_bin;
    end

    always_comb begin
        o_push       = r_s1_vld;
        o_cmd.kind   = r_s1_kind;
        o_cmd.dist_mm = r_s1_dist;
        unique case (r_s1_kind)
            REQ_POINT: begin
                o_cmd.bin     = (r_s1_q >= BINS_Q) ? BIN_W'(r_s1_q - BINS_Q) : BIN_W'(r_s1_q);
                o_cmd.bad_bin = 1'b0;
            end
            REQ_READ: begin
                o_cmd.bin     = r_s1_rbin;
                o_cmd.bad_bin = (r_s1_rbin > LAST_BIN);
            end
            default: begin
                o_cmd.bin     = r_s1_rbin;
                o_cmd.bad_bin = 1'b0;
            end
        endcase
    end
endmodule

// ===== rtl/lnab_fifo.sv =====
module lnab_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  lnab_pkg::t_cmd                  i_cmd,
    input  logic                            i_pop,
    output lnab_pkg::t_cmd                  o_head,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [lnab_pkg::FIFO_CNT_W-1:0] o_cnt
);
    import lnab_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_cnt   = r_cnt;
endmodule

// ===== rtl/lnab_back.sv =====
module lnab_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lnab_pkg::t_range     i_range,
    input  lnab_pkg::t_cmd       i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_res_strobe,
    output lnab_pkg::t_out_item  o_result
);
    import lnab_pkg::*;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [BIN_W-1:0]  r_clr_cnt;
    logic [BIN_W-1:0]  n_clr_cnt;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              r_res_vld;
    logic              n_res_vld;
    t_out_item         r_res;
    t_out_item         n_res;

    logic              w_we;
    logic [BIN_W-1:0]  w_waddr;
    logic [DIST_W-1:0] w_wdata;
    logic [BIN_W-1:0]  w_raddr;
    logic [DIST_W-1:0] w_rdata;

    lnab_ram #(
        .WIDTH (DIST_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_cnt == LAST_BIN) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_DATA;
                end
            end
            B_DATA:  n_state = B_IDLE;
            default: n_state = B_CLEAR;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        o_clearing = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_cmd.bin;
        w_wdata    = '0;
        w_raddr    = '0;
        n_clr_cnt  = r_clr_cnt;
        n_cmd      = r_cmd;
        n_res_vld  = 1'b0;
        n_res      = r_res;
        unique case (r_state)
            B_CLEAR: begin
                o_clearing = 1'b1;
                w_we       = 1'b1;
                w_waddr    = r_clr_cnt;
                n_clr_cnt  = r_clr_cnt + 1'b1;
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    w_raddr = i_head.bad_bin ? '0 : i_head.bin;
                end
            end
            B_DATA: begin
                unique case (r_cmd.kind)
                    REQ_POINT: begin
                        w_we    = (w_rdata == '0) || (r_cmd.dist_mm < w_rdata);
                        w_wdata = r_cmd.dist_mm;
                    end
                    REQ_READ: begin
                        w_we              = !r_cmd.bad_bin;
                        n_res_vld         = 1'b1;
                        n_res.out_bin     = r_cmd.bin;
                        n_res.out_dist_mm = r_cmd.bad_bin ? '0 : w_rdata;
                        n_res.out_valid   = !r_cmd.bad_bin && (w_rdata != '0)
                                            && (w_rdata >= i_range.min_mm)
                                            && (w_rdata <= i_range.max_mm);
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_clr_cnt <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_res_vld <= n_res_vld;
        end
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    assign o_res_strobe = r_res_vld;
    assign o_result     = r_res;
endmodule

// ===== rtl/lidar_nearest_per_angle_bin_top.sv =====
// Channel   Direction  Handshake                   Payload
// item      in         start & !busy               i_item   (t_in_item)
// result    out        o_res_strobe, one cycle     o_result (t_out_item)
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// Front: register, then bin multiply stage. Back: RAM read, then write and
// result; it takes no new transaction until the last is done. The readout
// strobe follows acceptance through the front stages, the queue and the
// back's read and data states. After reset all 360 RAM bins are cleared
// to zero with busy high. busy also rises when queued plus front-stage
// items reach the queue depth of 4. The receiver cannot stall results.
module lidar_nearest_per_angle_bin_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lnab_pkg::t_in_item             i_item,
    output logic                           o_res_strobe,
    output lnab_pkg::t_out_item            o_result,
    input  logic                           i_cfg_we,
    input  logic [lnab_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lnab_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import lnab_pkg::*;

    t_range                r_range;
    logic                  w_push;
    t_cmd                  w_cmd;
    t_cmd                  w_head;
    logic                  w_pop;
    logic                  w_empty;
    logic                  w_full;
    logic [FIFO_CNT_W-1:0] w_cnt;
    logic                  w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range.min_mm <= RANGE_MIN_RST;
            r_range.max_mm <= RANGE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_MIN: r_range.min_mm <= i_cfg_wdata;
                CFG_RANGE_MAX: r_range.max_mm <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lnab_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .i_fifo_cnt (w_cnt),
        .i_clearing (w_clearing),
        .o_busy     (busy),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    lnab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_cnt   (w_cnt)
    );

    lnab_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_range      (r_range),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_full || w_pop))
        else $error("queue overflow");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_res_strobe)
        else $error("result during clearing pass");

    a_valid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.out_valid) |->
            ((o_result.out_dist_mm != '0) && (o_result.out_dist_mm >= r_range.min_mm)
             && (o_result.out_dist_mm <= r_range.max_mm)))
        else $error("valid flag on out-of-range distance");

    a_bad_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_result.out_bin > LAST_BIN)) |->
            ((o_result.out_dist_mm == '0) && !o_result.out_valid))
        else $error("bad bin readout not empty");
endmodule
